[hw/rtl/point_polygon_sqdist_sum_defines.svh]
// Assertion macros for the point-to-polygon distance block.
// Used by the top level; no other dependencies.
`ifndef POINT_POLYGON_SQDIST_SUM_DEFINES_SVH
`define POINT_POLYGON_SQDIST_SUM_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk_i and disabled during reset.
`define PPSQ_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ppsq: assertion failed");
// Next-cycle implication, sampled on clk_i and disabled during reset.
`define PPSQ_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ppsq: assertion failed");
`else
`define PPSQ_ASSERT_IMP(label, ante, cons)
`define PPSQ_ASSERT_NXT(label, ante, cons)
`endif
`endif

[hw/rtl/ppsq_pkg.sv]
// Shared widths, codes and types for the point-to-polygon distance block.
// No dependencies.
`default_nettype none
package ppsq_pkg;

  localparam int SlotW          = 6;
  localparam int CoordW         = 32;
  localparam int DiffW          = CoordW + 1;
  localparam int ProdW          = 2 * DiffW;
  localparam int DistW          = 65;
  localparam int RemW           = DistW + 1;
  localparam int WideW          = ProdW + 1;
  localparam int NumW           = 2 * DistW;
  localparam int QuoBits        = DistW;
  localparam int OutW           = 64;
  localparam int VcntW          = 7;
  localparam int MaxVerticesDef = 64;

  localparam logic [VcntW-1:0] VcntReset = 7'd3;

  // Request operation codes.
  localparam logic OpLoad  = 1'b0;
  localparam logic OpPixel = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN
  } ppsq_state_e;

  // One segment after both table reads.
  typedef struct packed {
    logic                     last;
    logic [SlotW-1:0]         idx_i;
    logic [SlotW-1:0]         idx_j;
    logic signed [CoordW-1:0] x0;
    logic signed [CoordW-1:0] y0;
    logic signed [CoordW-1:0] x1;
    logic signed [CoordW-1:0] y1;
  } ppsq_seg_t;

  // One segment travelling down the divider chain.
  typedef struct packed {
    logic             last;
    logic             interior;
    logic [SlotW-1:0] idx;
    logic [DistW-1:0] dsq;
    logic [RemW-1:0]  rem;
    logic [DistW-1:0] acc;
  } ppsq_tok_t;

endpackage
`default_nettype wire

[hw/rtl/point_polygon_sqdist_sum.sv]
// Top level of the point-to-polygon squared distance block: vertex table,
// segment sequencer, divider chain, minimum search and running sum.
// Depends on ppsq_pkg, ppsq_seg_front, ppsq_div_cell and the defines header.
//
// Usage. A request is taken at a rising edge with start_i high and busy_o low.
// operation_i low stores one vertex (x, y, successor) into the table at
// vertex_slot_i; such a request gives no result and busy_o stays low, so loads
// may follow each other in every cycle. operation_i high processes one pixel:
// the sequencer issues one segment per cycle, vertex_count of them (at least
// one, at most MaxVertices), through a five-stage arithmetic front end and a
// chain of 65 division cells that each settle one quotient bit and hand the
// segment on every cycle. A minimum stage and the output register follow.
// The result shows on the result ports for one cycle with valid_o high.
// busy_o falls as the result is shown, so the next request may be taken in
// that cycle. The receiver cannot stall: valid_o is a plain strobe.
// The count register is written through cfg_valid_i/cfg_ready_o while idle.
// Reset clears the control state, the running sum and sets the count to 3.
// Table entries are undefined until loaded.
`default_nettype none
`include "point_polygon_sqdist_sum_defines.svh"
module point_polygon_sqdist_sum import ppsq_pkg::*; #(
  parameter int MaxVertices = MaxVerticesDef
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  output logic                          busy_o,
  input  wire logic                     operation_i,
  input  wire logic [SlotW-1:0]         vertex_slot_i,
  input  wire logic [SlotW-1:0]         successor_slot_i,
  input  wire logic signed [CoordW-1:0] coord_x_i,
  input  wire logic signed [CoordW-1:0] coord_y_i,
  input  wire logic                     restart_sum_i,
  output logic                          valid_o,
  output logic [OutW-1:0]               dist_sq_o,
  output logic [SlotW-1:0]              closest_vertex_o,
  output logic                          on_edge_o,
  output logic [OutW-1:0]               total_sum_o,
  input  wire logic                     cfg_valid_i,
  output logic                          cfg_ready_o,
  input  wire logic [VcntW-1:0]         cfg_data_i
);

  localparam int AW = $clog2(MaxVertices);
  localparam int CW = $clog2(MaxVertices + 1);

  ppsq_state_e state_q, state_d;
  logic        accept, pixel_go, issue, last_issue, fin_q;

  // Configuration register.
  logic [VcntW-1:0] vcnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcnt_q <= VcntReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      vcnt_q <= cfg_data_i;
    end
  end

  assign cfg_ready_o = !busy_o;
  assign accept      = start_i && !busy_o;
  assign pixel_go    = accept && (operation_i == OpPixel);

  // Pixel context and segment counter.
  logic signed [CoordW-1:0] px_q, py_q;
  logic                     restart_q;
  logic [CW-1:0]            cnt_q, i_q;

  always_ff @(posedge clk_i) begin
    if (pixel_go) begin
      px_q      <= coord_x_i;
      py_q      <= coord_y_i;
      restart_q <= restart_sum_i;
      if (int'(vcnt_q) > MaxVertices) begin
        cnt_q <= CW'(MaxVertices);
      end else if (vcnt_q == '0) begin
        cnt_q <= CW'(1);
      end else begin
        cnt_q <= CW'(vcnt_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0;
    end else if (pixel_go) begin
      i_q <= '0;
    end else if (issue) begin
      i_q <= i_q + 1'b1;
    end
  end

  assign last_issue = issue && (i_q == cnt_q - 1'b1);

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (pixel_go) state_d = ST_ISSUE;
      ST_ISSUE: if (last_issue) state_d = ST_DRAIN;
      ST_DRAIN: if (fin_q) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    busy_o = 1'b1;
    issue  = 1'b0;
    unique case (state_q)
      ST_IDLE:  busy_o = 1'b0;
      ST_ISSUE: issue  = 1'b1;
      ST_DRAIN: issue  = 1'b0;
      default:  busy_o = 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Vertex table: one write port, reads at the start and successor vertex.
  logic signed [CoordW-1:0] mem_x [MaxVertices];
  logic signed [CoordW-1:0] mem_y [MaxVertices];
  logic [SlotW-1:0]         mem_n [MaxVertices];
  logic                     load_ok;

  assign load_ok = accept && (operation_i == OpLoad) && (int'(vertex_slot_i) < MaxVertices);

  always_ff @(posedge clk_i) begin
    if (load_ok) begin
      mem_x[AW'(vertex_slot_i)] <= coord_x_i;
      mem_y[AW'(vertex_slot_i)] <= coord_y_i;
      mem_n[AW'(vertex_slot_i)] <= successor_slot_i;
    end
  end

  logic                     v1_q, v2_q, l1_q;
  logic [SlotW-1:0]         i1_q, n1_q;
  logic signed [CoordW-1:0] x0_q, y0_q;
  ppsq_seg_t                seg_q;
  logic                     oob;

  always_ff @(posedge clk_i) begin
    x0_q <= mem_x[AW'(i_q)];
    y0_q <= mem_y[AW'(i_q)];
    n1_q <= mem_n[AW'(i_q)];
    i1_q <= SlotW'(i_q);
    l1_q <= last_issue;
  end

  // A successor outside the table reads as the origin.
  assign oob = int'(n1_q) >= MaxVertices;

  always_ff @(posedge clk_i) begin
    seg_q.x1    <= oob ? '0 : mem_x[AW'(n1_q)];
    seg_q.y1    <= oob ? '0 : mem_y[AW'(n1_q)];
    seg_q.x0    <= x0_q;
    seg_q.y0    <= y0_q;
    seg_q.idx_i <= i1_q;
    seg_q.idx_j <= n1_q;
    seg_q.last  <= l1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= issue;
      v2_q <= v1_q;
    end
  end

  // Arithmetic front end and divider chain.
  logic      cvld [QuoBits+1];
  ppsq_tok_t ctok [QuoBits+1];

  ppsq_seg_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2_q),
    .seg_i   (seg_q),
    .px_i    (px_q),
    .py_i    (py_q),
    .valid_o (cvld[0]),
    .tok_o   (ctok[0])
  );

  for (genvar k = 0; k < QuoBits; k++) begin : g_cell
    ppsq_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (cvld[k]),
      .tok_i   (ctok[k]),
      .valid_o (cvld[k+1]),
      .tok_o   (ctok[k+1])
    );
  end

  // Minimum search: strict less keeps the earlier segment on a tie.
  logic             have_q;
  logic [DistW-1:0] best_q;
  logic [SlotW-1:0] bidx_q;
  logic             bedge_q;
  ppsq_tok_t        tend;

  assign tend = ctok[QuoBits];

  always_ff @(posedge clk_i) begin
    if (cvld[QuoBits] && (!have_q || (tend.acc < best_q))) begin
      best_q  <= tend.acc;
      bidx_q  <= tend.idx;
      bedge_q <= tend.interior;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
      fin_q  <= 1'b0;
    end else begin
      fin_q <= cvld[QuoBits] && tend.last;
      if (cvld[QuoBits]) begin
        have_q <= !tend.last;
      end
    end
  end

  // Saturation, running sum and output register.
  logic [OutW-1:0] d64, base;
  logic [OutW:0]   sum;
  logic            valid_q;
  logic [OutW-1:0] dist_q, total_q;
  logic [SlotW-1:0] cidx_q;
  logic            edge_q;

  assign d64  = best_q[DistW-1] ? '1 : best_q[OutW-1:0];
  assign base = restart_q ? '0 : total_q;
  assign sum  = {1'b0, base} + {1'b0, d64};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      total_q <= '0;
    end else begin
      valid_q <= fin_q;
      if (fin_q) begin
        total_q <= sum[OutW] ? '1 : sum[OutW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_q) begin
      dist_q <= d64;
      cidx_q <= bidx_q;
      edge_q <= bedge_q;
    end
  end

  assign valid_o          = valid_q;
  assign dist_sq_o        = dist_q;
  assign closest_vertex_o = cidx_q;
  assign on_edge_o        = edge_q;
  assign total_sum_o      = total_q;

  // Checks on sequencing and on the saturating sum.
  `PPSQ_ASSERT_IMP(a_result_after_busy, valid_o, $past(busy_o))
  `PPSQ_ASSERT_NXT(a_pixel_sets_busy, pixel_go, busy_o)
  `PPSQ_ASSERT_IMP(a_chain_only_busy, cvld[QuoBits], busy_o)
  `PPSQ_ASSERT_IMP(a_sum_covers_dist, valid_o, total_sum_o >= dist_sq_o)

endmodule
`default_nettype wire

[hw/rtl/ppsq_div_cell.sv]
// One restoring-division cell of the divider chain: one quotient bit per cell.
// Depends on ppsq_pkg.
`default_nettype none
module ppsq_div_cell import ppsq_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      valid_i,
  input  wire ppsq_tok_t tok_i,
  output logic           valid_o,
  output ppsq_tok_t      tok_o
);

  logic      valid_q;
  ppsq_tok_t tok_q, tok_d;
  logic [RemW-1:0] rem_sh;
  logic            ge;

  // Shift the next numerator bit into the remainder and try a subtraction.
  always_comb begin
    tok_d  = tok_i;
    rem_sh = {tok_i.rem[RemW-2:0], tok_i.acc[DistW-1]};
    ge     = rem_sh >= {1'b0, tok_i.dsq};
    if (tok_i.interior) begin
      tok_d.rem = ge ? (rem_sh - {1'b0, tok_i.dsq}) : rem_sh;
      tok_d.acc = {tok_i.acc[DistW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
  end

  assign valid_o = valid_q;
  assign tok_o   = tok_q;

endmodule
`default_nettype wire

[hw/rtl/ppsq_seg_front.sv]
// Segment arithmetic front end: differences, products, classification and the
// squared cross product that feeds the divider chain. Depends on ppsq_pkg.
`default_nettype none
module ppsq_seg_front import ppsq_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     valid_i,
  input  wire ppsq_seg_t                seg_i,
  input  wire logic signed [CoordW-1:0] px_i,
  input  wire logic signed [CoordW-1:0] py_i,
  output logic                          valid_o,
  output ppsq_tok_t                     tok_o
);

  logic [4:0] vld_q;

  // Stage one: coordinate differences.
  logic signed [DiffW-1:0] dx_q, dy_q, ex_q, ey_q, fx_q, fy_q;
  logic                    l1_q;
  logic [SlotW-1:0]        i1_q, j1_q;

  always_ff @(posedge clk_i) begin
    dx_q <= {seg_i.x1[CoordW-1], seg_i.x1} - {seg_i.x0[CoordW-1], seg_i.x0};
    dy_q <= {seg_i.y1[CoordW-1], seg_i.y1} - {seg_i.y0[CoordW-1], seg_i.y0};
    ex_q <= {px_i[CoordW-1], px_i} - {seg_i.x0[CoordW-1], seg_i.x0};
    ey_q <= {py_i[CoordW-1], py_i} - {seg_i.y0[CoordW-1], seg_i.y0};
    fx_q <= {px_i[CoordW-1], px_i} - {seg_i.x1[CoordW-1], seg_i.x1};
    fy_q <= {py_i[CoordW-1], py_i} - {seg_i.y1[CoordW-1], seg_i.y1};
    l1_q <= seg_i.last;
    i1_q <= seg_i.idx_i;
    j1_q <= seg_i.idx_j;
  end

  // Stage two: all first-level products in parallel.
  logic signed [ProdW-1:0] m_dxx, m_dyy, m_exdx, m_eydy, m_exdy, m_dxey;
  logic signed [ProdW-1:0] m_exx, m_eyy, m_fxx, m_fyy;
  logic signed [ProdW-1:0] dxx_q, dyy_q, exdx_q, eydy_q, exdy_q, dxey_q;
  logic signed [ProdW-1:0] exx_q, eyy_q, fxx_q, fyy_q;
  logic                    l2_q;
  logic [SlotW-1:0]        i2_q, j2_q;

  assign m_dxx  = dx_q * dx_q;
  assign m_dyy  = dy_q * dy_q;
  assign m_exdx = ex_q * dx_q;
  assign m_eydy = ey_q * dy_q;
  assign m_exdy = ex_q * dy_q;
  assign m_dxey = dx_q * ey_q;
  assign m_exx  = ex_q * ex_q;
  assign m_eyy  = ey_q * ey_q;
  assign m_fxx  = fx_q * fx_q;
  assign m_fyy  = fy_q * fy_q;

  always_ff @(posedge clk_i) begin
    dxx_q  <= m_dxx;
    dyy_q  <= m_dyy;
    exdx_q <= m_exdx;
    eydy_q <= m_eydy;
    exdy_q <= m_exdy;
    dxey_q <= m_dxey;
    exx_q  <= m_exx;
    eyy_q  <= m_eyy;
    fxx_q  <= m_fxx;
    fyy_q  <= m_fyy;
    l2_q   <= l1_q;
    i2_q   <= i1_q;
    j2_q   <= j1_q;
  end

  // Stage three: length, projection, cross product and vertex distances.
  logic [ProdW-1:0]        s_dsq, s_d0, s_d1;
  logic [DistW-1:0]        dsq_q, d0_q, d1_q;
  logic signed [WideW-1:0] dot_q, cr_q;
  logic                    l3_q;
  logic [SlotW-1:0]        i3_q, j3_q;

  assign s_dsq = dxx_q + dyy_q;
  assign s_d0  = exx_q + eyy_q;
  assign s_d1  = fxx_q + fyy_q;

  always_ff @(posedge clk_i) begin
    dsq_q <= s_dsq[DistW-1:0];
    d0_q  <= s_d0[DistW-1:0];
    d1_q  <= s_d1[DistW-1:0];
    dot_q <= {exdx_q[ProdW-1], exdx_q} + {eydy_q[ProdW-1], eydy_q};
    cr_q  <= {exdy_q[ProdW-1], exdy_q} - {dxey_q[ProdW-1], dxey_q};
    l3_q  <= l2_q;
    i3_q  <= i2_q;
    j3_q  <= j2_q;
  end

  // Stage four: classify the segment and square the cross product in parts.
  logic             at_start, at_end, inner;
  logic [WideW-1:0] cr_abs;
  logic [32:0]      cr_hi;
  logic [31:0]      cr_lo;
  logic [65:0]      m_hh;
  logic [64:0]      m_hl;
  logic [63:0]      m_ll;
  logic [65:0]      hh_q;
  logic [64:0]      hl_q;
  logic [63:0]      ll_q;
  logic             l4_q, in4_q;
  logic [SlotW-1:0] idx4_q;
  logic [DistW-1:0] d4_q, dsq4_q;

  assign at_start = (dsq_q == '0) || dot_q[WideW-1];
  assign at_end   = !at_start && ($signed({2'b00, dsq_q}) < dot_q);
  assign inner    = !at_start && !at_end;
  assign cr_abs   = cr_q[WideW-1] ? (~cr_q + 1'b1) : cr_q;
  assign cr_hi    = cr_abs[64:32];
  assign cr_lo    = cr_abs[31:0];
  assign m_hh     = cr_hi * cr_hi;
  assign m_hl     = cr_hi * cr_lo;
  assign m_ll     = cr_lo * cr_lo;

  always_ff @(posedge clk_i) begin
    hh_q   <= m_hh;
    hl_q   <= m_hl;
    ll_q   <= m_ll;
    l4_q   <= l3_q;
    in4_q  <= inner;
    idx4_q <= at_end ? j3_q : i3_q;
    d4_q   <= at_end ? d1_q : d0_q;
    dsq4_q <= dsq_q;
  end

  // Stage five: assemble the numerator and load the chain request.
  logic [NumW-1:0] num;
  ppsq_tok_t       tok_q;

  assign num = {hh_q, 64'b0} + {32'b0, hl_q, 33'b0} + {66'b0, ll_q};

  always_ff @(posedge clk_i) begin
    tok_q.last     <= l4_q;
    tok_q.interior <= in4_q;
    tok_q.idx      <= idx4_q;
    tok_q.dsq      <= dsq4_q;
    tok_q.rem      <= {1'b0, num[NumW-1:DistW]};
    tok_q.acc      <= in4_q ? num[DistW-1:0] : d4_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  assign valid_o = vld_q[4];
  assign tok_o   = tok_q;

endmodule
`default_nettype wire

[bench/ppsq_checker.sv]
// Checker for the point-to-polygon distance block: watches requests, the count
// register and results, predicts each pixel result and compares it.
// Depends on ppsq_pkg.
`timescale 1ns / 100ps
module ppsq_checker import ppsq_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic                     busy_o,
  input  wire logic                     operation_i,
  input  wire logic [SlotW-1:0]         vertex_slot_i,
  input  wire logic [SlotW-1:0]         successor_slot_i,
  input  wire logic signed [CoordW-1:0] coord_x_i,
  input  wire logic signed [CoordW-1:0] coord_y_i,
  input  wire logic                     restart_sum_i,
  input  wire logic                     valid_o,
  input  wire logic [OutW-1:0]          dist_sq_o,
  input  wire logic [SlotW-1:0]         closest_vertex_o,
  input  wire logic                     on_edge_o,
  input  wire logic [OutW-1:0]          total_sum_o,
  input  wire logic                     cfg_valid_i,
  input  wire logic                     cfg_ready_o,
  input  wire logic [VcntW-1:0]         cfg_data_i,
  output int                            fail_count_o,
  output int                            pending_o
);

  localparam int Depth = 64;

  typedef logic signed [191:0] wide_t;

  typedef struct {
    logic [OutW-1:0]  dist_sq;
    logic [SlotW-1:0] vtx;
    logic             on_edge;
    logic [OutW-1:0]  total;
  } pixel_result_t;

  logic signed [CoordW-1:0] tab_x [Depth];
  logic signed [CoordW-1:0] tab_y [Depth];
  logic [SlotW-1:0]         tab_next [Depth];
  logic [OutW-1:0]          sum_model;
  logic [VcntW-1:0]         count_model;
  pixel_result_t            awaited_results [$];
  int                       mismatches;

  assign fail_count_o = mismatches + awaited_results.size();
  assign pending_o    = awaited_results.size();

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string what, input logic [OutW-1:0] got,
                                 input logic [OutW-1:0] want);
    $display("tb: mismatch on %s: got %h, expected %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Nearest point of the outline to a pixel, and the updated running sum.
  function automatic pixel_result_t nearest_outline_point(
    input logic signed [CoordW-1:0] cx, input logic signed [CoordW-1:0] cy,
    input logic restart);
    pixel_result_t    res;
    wide_t            px, py, x0, y0, x1, y1, dx, dy, ex, ey, dsq, dot, d, best, cr;
    int               n, j;
    logic [SlotW-1:0] cand, best_idx;
    logic             flag, best_flag;
    logic [OutW:0]    acc;
    logic [OutW-1:0]  d64;
    n = count_model;
    if (n > Depth) n = Depth;
    if (n == 0) n = 1;
    px = cx;
    py = cy;
    best = '0;
    best_idx = '0;
    best_flag = 1'b0;
    for (int i = 0; i < n; i++) begin
      j = tab_next[i];
      x0 = tab_x[i];
      y0 = tab_y[i];
      x1 = tab_x[j];
      y1 = tab_y[j];
      dx = x1 - x0;
      dy = y1 - y0;
      ex = px - x0;
      ey = py - y0;
      dsq = dx * dx + dy * dy;
      dot = ex * dx + ey * dy;
      // A zero-length segment counts as its start vertex.
      if (dsq == 0 || dot < 0) begin
        d = ex * ex + ey * ey;
        cand = SlotW'(i);
        flag = 1'b0;
      end else if (dot > dsq) begin
        d = (px - x1) * (px - x1) + (py - y1) * (py - y1);
        cand = SlotW'(j);
        flag = 1'b0;
      end else begin
        cr = ex * dy - dx * ey;
        d = (cr * cr) / dsq;
        cand = SlotW'(i);
        flag = 1'b1;
      end
      // Strict minimum: the earlier segment keeps a tie.
      if (i == 0 || d < best) begin
        best = d;
        best_idx = cand;
        best_flag = flag;
      end
    end
    d64 = (best[191:64] != 0) ? {OutW{1'b1}} : best[63:0];
    acc = (restart ? {(OutW+1){1'b0}} : {1'b0, sum_model}) + {1'b0, d64};
    res.dist_sq = d64;
    res.vtx = best_idx;
    res.on_edge = best_flag;
    res.total = acc[OutW] ? {OutW{1'b1}} : acc[OutW-1:0];
    return res;
  endfunction

  // Track the register, the table and the sum; queue and compare results.
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_result_t want;
    if (!rst_ni) begin
      sum_model <= '0;
      count_model <= VcntReset;
      mismatches <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) count_model <= cfg_data_i;
      if (valid_o) begin
        if (awaited_results.size() == 0) begin
          $display("tb: unexpected result at %0t", $realtime);
          mismatches <= mismatches + 1;
        end else begin
          want = awaited_results.pop_front();
          if (dist_sq_o !== want.dist_sq) report_mismatch("dist_sq", dist_sq_o, want.dist_sq);
          if (closest_vertex_o !== want.vtx)
            report_mismatch("closest_vertex", closest_vertex_o, want.vtx);
          if (on_edge_o !== want.on_edge) report_mismatch("on_edge", on_edge_o, want.on_edge);
          if (total_sum_o !== want.total) report_mismatch("total_sum", total_sum_o, want.total);
        end
      end
      if (start_i && !busy_o) begin
        if (operation_i == OpLoad) begin
          tab_x[vertex_slot_i] <= coord_x_i;
          tab_y[vertex_slot_i] <= coord_y_i;
          tab_next[vertex_slot_i] <= successor_slot_i;
        end else begin
          want = nearest_outline_point(coord_x_i, coord_y_i, restart_sum_i);
          sum_model <= want.total;
          awaited_results.push_back(want);
        end
      end
    end
  end

endmodule

[bench/testbench.sv]
// Top of the bench: clock, reset, request and register stimulus, verdict.
// Depends on ppsq_pkg, point_polygon_sqdist_sum and ppsq_checker.
`timescale 1ns / 100ps
module testbench;
  import ppsq_pkg::*;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start_i;
  logic                     busy_o;
  logic                     operation_i;
  logic [SlotW-1:0]         vertex_slot_i;
  logic [SlotW-1:0]         successor_slot_i;
  logic signed [CoordW-1:0] coord_x_i;
  logic signed [CoordW-1:0] coord_y_i;
  logic                     restart_sum_i;
  logic                     valid_o;
  logic [OutW-1:0]          dist_sq_o;
  logic [SlotW-1:0]         closest_vertex_o;
  logic                     on_edge_o;
  logic [OutW-1:0]          total_sum_o;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [VcntW-1:0]         cfg_data_i;
  int                       fail_count;
  int                       pending;
  bit                       no_gaps;

  localparam logic signed [CoordW-1:0] CoordMax = 32'sh7fff_ffff;
  localparam logic signed [CoordW-1:0] CoordMin = 32'sh8000_0000;

  point_polygon_sqdist_sum u_top (.*);

  ppsq_checker u_checker (.*, .fail_count_o(fail_count), .pending_o(pending));

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hands one request over, keeping start high between back-to-back requests.
  task automatic send_request(input logic op, input logic [SlotW-1:0] slot,
                              input logic [SlotW-1:0] succ,
                              input logic signed [CoordW-1:0] x,
                              input logic signed [CoordW-1:0] y, input logic restart);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    operation_i <= op;
    vertex_slot_i <= slot;
    successor_slot_i <= succ;
    coord_x_i <= x;
    coord_y_i <= y;
    restart_sum_i <= restart;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Writes the count register once the block has drained.
  task automatic write_count(input logic [VcntW-1:0] value);
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Coordinates: mostly close together, some full range, some extremes.
  function automatic logic signed [CoordW-1:0] pick_coord();
    int mode;
    mode = $urandom_range(0, 9);
    if (mode < 6) return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
    if (mode < 9) return $urandom;
    return $urandom_range(0, 1) ? CoordMax : CoordMin;
  endfunction

  initial begin
    logic [VcntW-1:0] counts [14];
    start_i = 1'b0;
    operation_i = OpLoad;
    vertex_slot_i = '0;
    successor_slot_i = '0;
    coord_x_i = '0;
    coord_y_i = '0;
    restart_sum_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    no_gaps = 1'b0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill the whole table first so that no pixel reads an unloaded entry.
    no_gaps = 1'b1;
    for (int s = 0; s < 64; s++)
      send_request(OpLoad, SlotW'(s), SlotW'((s + 1) % 64), pick_coord(), pick_coord(), 1'b0);
    no_gaps = 1'b0;

    // A unit square in slots 0..3, a zero-length segment at slot 4, and
    // vertices at both corners of the coordinate range in slots 5 and 6.
    send_request(OpLoad, 6'd0, 6'd1, 32'sh0000_0000, 32'sh0000_0000, 1'b0);
    send_request(OpLoad, 6'd1, 6'd2, 32'sh0001_0000, 32'sh0000_0000, 1'b0);
    send_request(OpLoad, 6'd2, 6'd3, 32'sh0001_0000, 32'sh0001_0000, 1'b0);
    send_request(OpLoad, 6'd3, 6'd4, 32'sh0000_0000, 32'sh0001_0000, 1'b0);
    send_request(OpLoad, 6'd4, 6'd4, 32'sh0000_8000, 32'sh0000_8000, 1'b0);
    send_request(OpLoad, 6'd5, 6'd6, CoordMax, CoordMax, 1'b0);
    send_request(OpLoad, 6'd6, 6'd63, CoordMin, CoordMin, 1'b0);
    send_request(OpLoad, 6'd63, 6'd0, CoordMin, CoordMax, 1'b0);
    // Default count 3: interior, at a vertex, beyond an end vertex, before a start vertex.
    send_request(OpPixel, 6'd0, 6'd0, 32'sh0000_8000, 32'sh0000_4000, 1'b1);
    send_request(OpPixel, 6'd0, 6'd0, 32'sh0001_0000, 32'sh0000_0000, 1'b0);
    send_request(OpPixel, 6'd0, 6'd0, 32'sh0003_0000, 32'sh0003_0000, 1'b0);
    send_request(OpPixel, 6'd0, 6'd0, 32'shffff_0000, 32'shfffe_0000, 1'b0);
    write_count(7'd64);
    // Whole table including the zero-length segment and the far corners.
    send_request(OpPixel, 6'd0, 6'd0, 32'sh0000_8000, 32'sh0000_8000, 1'b0);
    send_request(OpPixel, 6'd0, 6'd0, CoordMax, CoordMin, 1'b0);
    send_request(OpPixel, 6'd0, 6'd0, CoordMin, CoordMax, 1'b0);
    write_count(7'd6);
    // Pixels at both ends of the corner-to-corner segment, then at the origin with the sum restarted.
    send_request(OpPixel, 6'd0, 6'd0, CoordMin, CoordMin, 1'b1);
    send_request(OpPixel, 6'd0, 6'd0, CoordMax, CoordMax, 1'b0);
    send_request(OpPixel, 6'd0, 6'd0, CoordMin, CoordMin, 1'b0);
    send_request(OpPixel, 6'd0, 6'd0, 32'sh0000_0000, 32'sh0000_0000, 1'b1);

    counts = '{7'd2, 7'd3, 7'd64, 7'd0, 7'd1, 7'd127, 7'd100, 7'd5, 7'd63, 7'd2,
               7'd16, 7'd65, 7'd8, 7'd3};
    for (int p = 0; p < 14; p++) begin
      write_count(p == 13 ? VcntW'($urandom_range(2, 64)) : counts[p]);
      for (int k = 0; k < 100; k++) begin
        no_gaps = (k >= 40 && k < 60);
        if ($urandom_range(0, 9) < 4)
          send_request(OpLoad, SlotW'($urandom), SlotW'($urandom), pick_coord(), pick_coord(),
                       1'($urandom));
        else
          send_request(OpPixel, SlotW'($urandom), SlotW'($urandom), pick_coord(), pick_coord(),
                       ($urandom_range(0, 9) == 0));
      end
    end
    start_i <= 1'b0;

    // Drain, then give the pipeline time to show anything stray.
    while (pending != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #8ms;
    $display("tb: failure");
    $finish;
  end

endmodule

[point_polygon_sqdist_sum.f]
+incdir+hw/rtl
hw/rtl/ppsq_pkg.sv
hw/rtl/ppsq_div_cell.sv
hw/rtl/ppsq_seg_front.sv
hw/rtl/point_polygon_sqdist_sum.sv
bench/ppsq_checker.sv
bench/testbench.sv
